// ----- rtl/core/crot_pkg.sv -----
`default_nettype none

package crot_pkg;

	// Entry and result formats
	localparam int ENTRY_WIDTH = 16;
	localparam int OUT_WIDTH   = 16;

	// Similarity sum/difference before and after range reduction
	localparam int SUM_WIDTH   = ENTRY_WIDTH + 1;
	localparam int RED_WIDTH   = 15;
	localparam int EXT_WIDTH   = (SUM_WIDTH > RED_WIDTH) ? SUM_WIDTH : RED_WIDTH;
	localparam int SHIFT_WIDTH = $clog2(EXT_WIDTH + 1);

	// Squares, norm and root search
	localparam int SQ_WIDTH    = 2 * RED_WIDTH;
	localparam int NORM_WIDTH  = SQ_WIDTH + 1;
	localparam int ROOT_WIDTH  = 16;
	localparam int RHS_WIDTH   = SQ_WIDTH + 2 * (ROOT_WIDTH - 1);
	localparam int CROSS_WIDTH = NORM_WIDTH + ROOT_WIDTH;
	localparam int CAND_WIDTH  = CROSS_WIDTH + ROOT_WIDTH + 1;

	localparam int FRONT_STAGES = 4;

	localparam logic [OUT_WIDTH-1:0] ONE_Q14 = OUT_WIDTH'(16384);

	typedef struct packed {
		logic signed [ENTRY_WIDTH-1:0] a_row0_col0;
		logic signed [ENTRY_WIDTH-1:0] a_row1_col0;
		logic signed [ENTRY_WIDTH-1:0] a_row0_col1;
		logic signed [ENTRY_WIDTH-1:0] a_row1_col1;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] r_row0_col0;
		logic signed [OUT_WIDTH-1:0] r_row1_col0;
		logic signed [OUT_WIDTH-1:0] r_row0_col1;
		logic signed [OUT_WIDTH-1:0] r_row1_col1;
		logic                        degenerate;
	} out_item_t;

	typedef struct packed {
		logic c_neg;
		logic s_neg;
		logic degen;
	} meta_t;

	typedef struct packed {
		meta_t                  meta;
		logic [NORM_WIDTH-1:0]  norm;
		logic [RHS_WIDTH-1:0]   rhs_c;
		logic [RHS_WIDTH-1:0]   rhs_s;
	} front_t;

endpackage

`default_nettype wire

// ----- rtl/core/crot_front.sv -----
`default_nettype none

module crot_front import crot_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_item_t in_item,
	output logic          out_valid,
	output front_t        out_data
);

	function automatic logic signed [SUM_WIDTH-1:0] widen(input logic [ENTRY_WIDTH-1:0] v);
		return $signed({v[ENTRY_WIDTH-1], v});
	endfunction

	logic                        valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [SUM_WIDTH-1:0] csum_s1, sdif_s1;
	logic [RED_WIDTH-1:0]        cred_s2, sred_s2;
	meta_t                       meta_s2, meta_s3, meta_s4;
	logic [SQ_WIDTH-1:0]         csq_s3, ssq_s3;
	logic [NORM_WIDTH-1:0]       norm_s4;
	logic [RHS_WIDTH-1:0]        rhs_c_s4, rhs_s_s4;

	logic [SUM_WIDTH-1:0]   cmag, smag, mag_or;
	logic [SHIFT_WIDTH-1:0] shift;
	logic [EXT_WIDTH-1:0]   cext, sext;

	// Magnitudes, then drop low bits until both fit the reduced width
	always_comb begin
		cmag = csum_s1[SUM_WIDTH-1] ? $unsigned(-csum_s1) : $unsigned(csum_s1);
		smag = sdif_s1[SUM_WIDTH-1] ? $unsigned(-sdif_s1) : $unsigned(sdif_s1);
		mag_or = cmag | smag;
		shift = '0;
		for (int i = RED_WIDTH; i < SUM_WIDTH; i++) begin
			if (mag_or[i]) begin
				shift = SHIFT_WIDTH'(i - RED_WIDTH + 1);
			end
		end
		cext = EXT_WIDTH'(cmag) >> shift;
		sext = EXT_WIDTH'(smag) >> shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		csum_s1 <= widen(in_item.a_row0_col0) + widen(in_item.a_row1_col1);
		sdif_s1 <= widen(in_item.a_row0_col1) - widen(in_item.a_row1_col0);

		cred_s2       <= RED_WIDTH'(cext);
		sred_s2       <= RED_WIDTH'(sext);
		meta_s2.c_neg <= csum_s1[SUM_WIDTH-1];
		meta_s2.s_neg <= sdif_s1[SUM_WIDTH-1];
		meta_s2.degen <= (csum_s1 == '0) && (sdif_s1 == '0);

		csq_s3  <= SQ_WIDTH'(cred_s2) * SQ_WIDTH'(cred_s2);
		ssq_s3  <= SQ_WIDTH'(sred_s2) * SQ_WIDTH'(sred_s2);
		meta_s3 <= meta_s2;

		norm_s4  <= NORM_WIDTH'(csq_s3) + NORM_WIDTH'(ssq_s3);
		rhs_c_s4 <= RHS_WIDTH'(csq_s3) << (RHS_WIDTH - SQ_WIDTH);
		rhs_s_s4 <= RHS_WIDTH'(ssq_s3) << (RHS_WIDTH - SQ_WIDTH);
		meta_s4  <= meta_s3;
	end

	assign out_valid      = valid_s4;
	assign out_data.meta  = meta_s4;
	assign out_data.norm  = norm_s4;
	assign out_data.rhs_c = rhs_c_s4;
	assign out_data.rhs_s = rhs_s_s4;

endmodule

`default_nettype wire

// ----- rtl/core/crot_root_lane.sv -----
`default_nettype none

// Largest root with root^2 * norm <= rhs, one bit per stage, MSB first.
// Keep root^2*norm and root*norm so each trial is shifts and adds only.
module crot_root_lane import crot_pkg::*; (
	input  wire logic                  clk,
	input  wire logic [NORM_WIDTH-1:0] norm,
	input  wire logic [RHS_WIDTH-1:0]  rhs,
	output logic [ROOT_WIDTH-1:0]      root
);

	logic [NORM_WIDTH-1:0]  norm_s  [1:ROOT_WIDTH-1];
	logic [RHS_WIDTH-1:0]   rhs_s   [1:ROOT_WIDTH-1];
	logic [RHS_WIDTH-1:0]   prod_s  [1:ROOT_WIDTH-1];
	logic [CROSS_WIDTH-1:0] cross_s [1:ROOT_WIDTH-1];
	logic [ROOT_WIDTH-1:0]  root_s  [1:ROOT_WIDTH];

	for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
		localparam int BIT = ROOT_WIDTH - 1 - k;

		logic [NORM_WIDTH-1:0]  n_in;
		logic [RHS_WIDTH-1:0]   r_in;
		logic [RHS_WIDTH-1:0]   p_in;
		logic [CROSS_WIDTH-1:0] x_in;
		logic [ROOT_WIDTH-1:0]  q_in;
		logic [CAND_WIDTH-1:0]  cand;
		logic                   take;

		if (k == 0) begin : g_head
			assign n_in = norm;
			assign r_in = rhs;
			assign p_in = '0;
			assign x_in = '0;
			assign q_in = '0;
		end else begin : g_body
			assign n_in = norm_s[k];
			assign r_in = rhs_s[k];
			assign p_in = prod_s[k];
			assign x_in = cross_s[k];
			assign q_in = root_s[k];
		end

		// (q + 2^b)^2 n = q^2 n + 2^(b+1) q n + 2^(2b) n
		always_comb begin
			cand = CAND_WIDTH'(p_in) + (CAND_WIDTH'(x_in) << (BIT + 1))
				+ (CAND_WIDTH'(n_in) << (2 * BIT));
			take = cand <= CAND_WIDTH'(r_in);
		end

		always_ff @(posedge clk) begin
			root_s[k+1] <= take ? (q_in | (ROOT_WIDTH'(1) << BIT)) : q_in;
		end

		if (k < ROOT_WIDTH - 1) begin : g_carry
			always_ff @(posedge clk) begin
				norm_s[k+1]  <= n_in;
				rhs_s[k+1]   <= r_in;
				prod_s[k+1]  <= take ? RHS_WIDTH'(cand) : p_in;
				cross_s[k+1] <= take ? (x_in + (CROSS_WIDTH'(n_in) << BIT)) : x_in;
			end
		end
	end

	assign root = root_s[ROOT_WIDTH];

endmodule

`default_nettype wire

// ----- rtl/core/closest_rotation_2x2.sv -----
`default_nettype none

// Nearest plane rotation of a 2x2 block. Pulse start with a block on item
// (four column-major Q3.12 entries); the block takes one item every clock
// and busy stays low, so items may stream back to back without gaps. Each
// result sits on result for exactly one cycle with done high, in the order the
// items went in; the receiver must take it in that cycle since there is no
// way to hold it. The path is four front stages (sum/difference, range
// reduction, squaring, norm), sixteen root-search stages (one root bit each,
// c and s in parallel lanes), and the output register. Results are
// [[c,s],[-s,c]] in Q1.14, column-major, with c and s rounded half up and
// never beyond +/-1.0. A block whose similarity part is zero returns the
// identity with degenerate set. There is no configuration and no state
// across items.
module closest_rotation_2x2 import crot_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	output logic          done,
	output out_item_t     result
);

	localparam int LATENCY = FRONT_STAGES + ROOT_WIDTH + 1;

	logic                  front_valid;
	front_t                front_data;
	logic [ROOT_WIDTH-1:0] root_c, root_s;

	logic                  valid_s [1:ROOT_WIDTH];
	meta_t                 meta_s  [1:ROOT_WIDTH];

	logic [ROOT_WIDTH:0]   c_up, s_up;
	logic [OUT_WIDTH-1:0]  cq, sq, c_val, s_pos, s_neg;
	out_item_t             next_result;

	out_item_t             result_q;
	logic                  done_q;

	// Never stall: every stage advances every cycle
	assign busy = 1'b0;

	crot_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.in_item  (item),
		.out_valid(front_valid),
		.out_data (front_data)
	);

	// Root of 2^30 X^2 / N for each component
	crot_root_lane u_lane_c (
		.clk (clk),
		.norm(front_data.norm),
		.rhs (front_data.rhs_c),
		.root(root_c)
	);

	crot_root_lane u_lane_s (
		.clk (clk),
		.norm(front_data.norm),
		.rhs (front_data.rhs_s),
		.root(root_s)
	);

	// Carry valid and signs alongside the root lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ROOT_WIDTH; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else begin
			valid_s[1] <= front_valid;
			for (int i = 2; i <= ROOT_WIDTH; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		meta_s[1] <= front_data.meta;
		for (int i = 2; i <= ROOT_WIDTH; i++) begin
			meta_s[i] <= meta_s[i-1];
		end
	end

	// Count of odd numbers up to the root gives the rounded Q1.14 value;
	// apply signs and drop to identity for a zero similarity part.
	always_comb begin
		c_up  = ({1'b0, root_c} + 1'b1) >> 1;
		s_up  = ({1'b0, root_s} + 1'b1) >> 1;
		cq    = OUT_WIDTH'(c_up);
		sq    = OUT_WIDTH'(s_up);
		c_val = meta_s[ROOT_WIDTH].c_neg ? (~cq + 1'b1) : cq;
		s_pos = meta_s[ROOT_WIDTH].s_neg ? (~sq + 1'b1) : sq;
		s_neg = meta_s[ROOT_WIDTH].s_neg ? sq : (~sq + 1'b1);
		if (meta_s[ROOT_WIDTH].degen) begin
			next_result.r_row0_col0 = ONE_Q14;
			next_result.r_row1_col0 = '0;
			next_result.r_row0_col1 = '0;
			next_result.r_row1_col1 = ONE_Q14;
			next_result.degenerate  = 1'b1;
		end else begin
			next_result.r_row0_col0 = c_val;
			next_result.r_row1_col0 = s_neg;
			next_result.r_row0_col1 = s_pos;
			next_result.r_row1_col1 = c_val;
			next_result.degenerate  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s[ROOT_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= next_result;
	end

	assign done   = done_q;
	assign result = result_q;

	// Every accepted item comes out with done high
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item did not produce a result on time");

	// No result without a matching accepted item
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching accepted item");

	// Rotation shape: equal diagonal, opposite off-diagonal
	a_rot_shape: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.r_row0_col0 == result.r_row1_col1)
			&& (result.r_row1_col0 == -result.r_row0_col1))
		else $error("result is not a rotation");

	// Degenerate items return the identity
	a_degen_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.degenerate) |-> (result.r_row0_col0 == ONE_Q14)
			&& (result.r_row0_col1 == '0))
		else $error("degenerate item did not return identity");

endmodule

`default_nettype wire
